>>> rtl/hbkrd_pkg.sv
// Shared types, constants and the keycode-to-ASCII map for the HID boot
// keyboard report decoder.
// No dependencies.
package hbkrd_pkg;

	localparam int KEY_SLOTS      = 6;
	localparam int BOOT_KEY_BYTES = 6;
	localparam int RAW_BYTES      = 9;

	localparam logic [7:0] SHIFT_MASK  = 8'h22;
	localparam logic [6:0] MIN_LEN     = 7'd8;
	localparam logic [6:0] REPORT_ID_LEN = 7'd9;
	localparam logic       ACT_CONNECT = 1'b1;

	typedef logic [7:0] byte_t;

	// Per-slot result handed from a lane to the merge stage
	typedef struct packed {
		logic  is_new;
		byte_t ascii;
	} lane_res_t;

	localparam byte_t SHIFTED_DIGITS [10] = '{
		8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29
	};

	// US-QWERTY map; unmapped keys give 0
	function automatic byte_t key_to_ascii(input byte_t kc, input logic sh);
		byte_t      r;
		logic [3:0] d;
		r = 8'h00;
		d = 4'(kc - 8'h1E);
		if (kc >= 8'h04 && kc <= 8'h1D) begin
			r = (sh ? 8'h41 : 8'h61) + (kc - 8'h04);
		end else if (kc >= 8'h1E && kc <= 8'h27) begin
			if (sh) begin
				r = SHIFTED_DIGITS[d];
			end else if (kc == 8'h27) begin
				r = 8'h30;
			end else begin
				r = 8'h31 + 8'(d);
			end
		end else begin
			unique case (kc)
				8'h28: r = 8'h0A;
				8'h2A: r = 8'h08;
				8'h2B: r = 8'h09;
				8'h2C: r = 8'h20;
				8'h2D: r = sh ? 8'h5F : 8'h2D;
				8'h2E: r = sh ? 8'h2B : 8'h3D;
				8'h2F: r = sh ? 8'h7B : 8'h5B;
				8'h30: r = sh ? 8'h7D : 8'h5D;
				8'h31: r = sh ? 8'h7C : 8'h5C;
				8'h33: r = sh ? 8'h3A : 8'h3B;
				8'h34: r = sh ? 8'h22 : 8'h27;
				8'h36: r = sh ? 8'h3C : 8'h2C;
				8'h37: r = sh ? 8'h3E : 8'h2E;
				8'h38: r = sh ? 8'h3F : 8'h2F;
				default: r = 8'h00;
			endcase
		end
		return r;
	endfunction

endpackage

>>> rtl/hbkrd_lane.sv
// One key-slot lane: checks the slot's keycode against the stored keys and
// maps it to ASCII.
// Depends on hbkrd_pkg.
module hbkrd_lane (
	input  hbkrd_pkg::byte_t     key,
	input  hbkrd_pkg::byte_t     prev [hbkrd_pkg::KEY_SLOTS],
	input  logic                 shift,
	output hbkrd_pkg::lane_res_t res
);
	import hbkrd_pkg::*;

	logic seen;

	// key was already held in the previous report
	always_comb begin
		seen = 1'b0;
		for (int j = 0; j < KEY_SLOTS; j++) begin
			seen = seen | (prev[j] == key);
		end
	end

	assign res.is_new = (key != 8'h00) && !seen;
	assign res.ascii  = key_to_ascii(key, shift);

endmodule

>>> rtl/hbkrd_merge.sv
// Merge stage: latches the lane results of one report and emits the new
// keys in slot order, one word per cycle while out_ready is high, through an output register.
// Depends on hbkrd_pkg.
module hbkrd_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  hbkrd_pkg::byte_t     keys     [hbkrd_pkg::KEY_SLOTS],
	input  hbkrd_pkg::lane_res_t lane_res [hbkrd_pkg::KEY_SLOTS],
	input  hbkrd_pkg::byte_t     mods,
	output logic                 busy,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hbkrd_pkg::byte_t     ascii_code,
	output hbkrd_pkg::byte_t     key_code,
	output hbkrd_pkg::byte_t     modifier_bits,
	output logic                 last_of_report
);
	import hbkrd_pkg::*;

	logic [KEY_SLOTS-1:0] pend_q;
	byte_t                key_q   [KEY_SLOTS];
	byte_t                ascii_q [KEY_SLOTS];
	byte_t                mods_q;

	logic [KEY_SLOTS-1:0] sel;
	logic [KEY_SLOTS-1:0] rest;
	logic                 found;
	logic                 emit;
	byte_t                key_pick;
	byte_t                ascii_pick;

	logic                 out_valid_q;
	byte_t                ascii_q_out;
	byte_t                key_q_out;
	byte_t                mods_q_out;
	logic                 last_q;

	// lowest pending slot goes next
	always_comb begin
		sel        = '0;
		found      = 1'b0;
		key_pick   = 8'h00;
		ascii_pick = 8'h00;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (pend_q[i] && !found) begin
				sel[i] = 1'b1;
				found  = 1'b1;
			end
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (sel[i]) begin
				key_pick   = key_pick | key_q[i];
				ascii_pick = ascii_pick | ascii_q[i];
			end
		end
	end

	assign rest = pend_q & ~sel;
	assign emit = (|pend_q) && (!out_valid_q || out_ready);

	// pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				pend_q[i] <= lane_res[i].is_new;
			end
		end else if (emit) begin
			pend_q <= rest;
		end
	end

	// per-slot payload
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				key_q[i]   <= keys[i];
				ascii_q[i] <= lane_res[i].ascii;
			end
			mods_q <= mods;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ascii_q_out <= ascii_pick;
			key_q_out   <= key_pick;
			mods_q_out  <= mods_q;
			last_q      <= (rest == '0);
		end
	end

	assign busy           = |pend_q;
	assign out_valid      = out_valid_q;
	assign ascii_code     = ascii_q_out;
	assign key_code       = key_q_out;
	assign modifier_bits  = mods_q_out;
	assign last_of_report = last_q;

`ifndef SYNTHESIS
	a_load_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (pend_q == '0))
		else $error("report loaded while keys still pending");
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel))
		else $error("more than one slot selected");
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (rest == '0)) |=> (pend_q == '0) && last_of_report)
		else $error("last word emitted with keys left pending");
	a_emit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid)
		else $error("emitted word not shown on output");
`endif

endmodule

>>> rtl/hid_boot_keyboard_report_decoder.sv
// HID boot keyboard report decoder, top level.
// Depends on hbkrd_pkg, hbkrd_lane, hbkrd_merge.
//
// Takes one boot-keyboard report (or a connect event) per input word and
// emits one output word per newly pressed key, in slot order, with the
// last one flagged. An accepted report is registered, compared in six
// parallel lanes against the stored keys in the next cycle, and its new
// keys then leave through the output register at one per cycle while
// out_ready is high. Connect events and reports shorter than 8 bytes are
// not compared and do not hold off the next input word.
// The next input word is taken once the last key of the previous report
// has moved into the output register.
module hid_boot_keyboard_report_decoder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic [6:0]       report_length,
	input  hbkrd_pkg::byte_t byte_0,
	input  hbkrd_pkg::byte_t byte_1,
	input  hbkrd_pkg::byte_t byte_2,
	input  hbkrd_pkg::byte_t byte_3,
	input  hbkrd_pkg::byte_t byte_4,
	input  hbkrd_pkg::byte_t byte_5,
	input  hbkrd_pkg::byte_t byte_6,
	input  hbkrd_pkg::byte_t byte_7,
	input  hbkrd_pkg::byte_t byte_8,
	output logic             out_valid,
	input  logic             out_ready,
	output hbkrd_pkg::byte_t ascii_code,
	output hbkrd_pkg::byte_t key_code,
	output hbkrd_pkg::byte_t modifier_bits,
	output logic             last_of_report
);
	import hbkrd_pkg::*;

	byte_t     raw [RAW_BYTES];
	byte_t     cur [KEY_SLOTS];
	byte_t     mods_w;
	logic      skip_id;
	logic      accept;
	logic      busy;

	logic      valid_s1;
	byte_t     key_s1 [KEY_SLOTS];
	byte_t     mods_s1;
	byte_t     prev_q [KEY_SLOTS];
	lane_res_t lane_res [KEY_SLOTS];

	assign raw[0] = byte_0;
	assign raw[1] = byte_1;
	assign raw[2] = byte_2;
	assign raw[3] = byte_3;
	assign raw[4] = byte_4;
	assign raw[5] = byte_5;
	assign raw[6] = byte_6;
	assign raw[7] = byte_7;
	assign raw[8] = byte_8;

	// report-ID prefix shifts everything by one byte
	assign skip_id = (report_length == REPORT_ID_LEN);
	assign mods_w  = skip_id ? raw[1] : raw[0];

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (i < BOOT_KEY_BYTES) begin
				cur[i] = skip_id ? raw[i + 3] : raw[i + 2];
			end else begin
				cur[i] = 8'h00;
			end
		end
	end

	assign in_ready = !valid_s1 && !busy;
	assign accept   = in_valid && in_ready;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (action != ACT_CONNECT) && (report_length >= MIN_LEN);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1  <= cur;
			mods_s1 <= mods_w;
		end
	end

	// stored keys: cleared on connect, replaced when a report is compared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_q[i] <= 8'h00;
			end
		end else if (accept && (action == ACT_CONNECT)) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_q[i] <= 8'h00;
			end
		end else if (valid_s1) begin
			prev_q <= key_s1;
		end
	end

	// one lane per key slot
	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
		hbkrd_lane u_lane (
			.key   (key_s1[g]),
			.prev  (prev_q),
			.shift ((mods_s1 & SHIFT_MASK) != 8'h00),
			.res   (lane_res[g])
		);
	end

	hbkrd_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (valid_s1),
		.keys           (key_s1),
		.lane_res       (lane_res),
		.mods           (mods_s1),
		.busy           (busy),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ascii_code     (ascii_code),
		.key_code       (key_code),
		.modifier_bits  (modifier_bits),
		.last_of_report (last_of_report)
	);

endmodule

>>> test/hid_boot_keyboard_report_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench for hid_boot_keyboard_report_decoder: a directed table of reports, then random
// keystroke sequences, every output word checked against a behavioral decoder or a typed row's result.
// Depends on hbkrd_pkg and the decoder RTL.
module hid_boot_keyboard_report_decoder_tb;
	import hbkrd_pkg::*;

	localparam logic ACT_REPORT  = 1'b0;
	localparam int   RAND_WORDS  = 410;
	localparam int   MAX_GAP     = 12;
	localparam int   CYCLE_LIMIT = 400000;
	localparam int   TAIL_CYCLES = 16;

	// one decoded key press, as it leaves the block
	typedef struct packed {
		byte_t ascii;
		byte_t key;
		byte_t mods;
		logic  last;
	} key_event_t;

	// one input word; b[0] is byte_0. typed rows carry their single result
	typedef struct packed {
		logic            act;
		logic [6:0]      len;
		logic [0:8][7:0] b;
		logic            typed;
		key_event_t      ev;
	} report_word_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       action;
	logic [6:0] report_length;
	byte_t      byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7, byte_8;
	logic       out_valid;
	logic       out_ready;
	byte_t      ascii_code;
	byte_t      key_code;
	byte_t      modifier_bits;
	logic       last_of_report;

	byte_t      held_keys [KEY_SLOTS];
	key_event_t pending_keys [$];
	int         fail_cnt;
	int         cycles;
	logic       tx_calm;
	logic       rx_calm;

	localparam string DIGITS_LO = "1234567890";
	localparam string DIGITS_HI = "!@#$%^&*()";

	// directed reports: after reset, shift sources, report ID, short and long lengths,
	// every mapped symbol and control key, unmapped keys, repeated new key, keycode extremes, connect
	localparam report_word_t DIRECTED [22] = '{
		'{ACT_CONNECT, 7'd9,   72'hFF_FF_FF_FF_FF_FF_FF_FF_FF, 1'b0, '0},
		'{ACT_REPORT,  7'd8,   72'h00_00_04_00_00_00_00_00_00, 1'b1, '{8'h61, 8'h04, 8'h00, 1'b1}},
		'{ACT_REPORT,  7'd8,   72'h00_00_04_00_00_00_00_00_00, 1'b0, '0},
		'{ACT_REPORT,  7'd8,   72'h00_00_00_00_00_00_00_00_00, 1'b0, '0},
		'{ACT_REPORT,  7'd9,   72'h01_02_00_1D_00_00_00_00_00, 1'b1, '{8'h5A, 8'h1D, 8'h02, 1'b1}},
		'{ACT_REPORT,  7'd8,   72'h20_00_1E_00_00_00_00_00_00, 1'b1, '{8'h21, 8'h1E, 8'h20, 1'b1}},
		'{ACT_REPORT,  7'd7,   72'h00_00_04_05_06_07_08_09_0A, 1'b0, '0},
		'{ACT_REPORT,  7'd0,   72'hFF_FF_FF_FF_FF_FF_FF_FF_FF, 1'b0, '0},
		'{ACT_REPORT,  7'd10,  72'h00_00_27_00_00_00_00_00_04, 1'b1, '{8'h30, 8'h27, 8'h00, 1'b1}},
		'{ACT_REPORT,  7'd127, 72'hFF_FF_28_2A_2B_2C_2D_38_00, 1'b0, '0},
		'{ACT_REPORT,  7'd64,  72'hDD_00_2E_2F_30_31_33_34_00, 1'b0, '0},
		'{ACT_REPORT,  7'd8,   72'h22_00_36_37_38_32_35_39_00, 1'b0, '0},
		'{ACT_REPORT,  7'd8,   72'h00_00_05_05_05_00_05_06_00, 1'b0, '0},
		'{ACT_REPORT,  7'd8,   72'h00_00_29_00_00_00_00_00_00, 1'b1, '{8'h00, 8'h29, 8'h00, 1'b1}},
		'{ACT_REPORT,  7'd8,   72'hFF_00_01_FF_03_1D_80_7F_00, 1'b0, '0},
		'{ACT_CONNECT, 7'd8,   72'h00_00_00_00_00_00_00_00_00, 1'b0, '0},
		'{ACT_REPORT,  7'd8,   72'hFF_00_01_FF_03_1D_80_7F_00, 1'b0, '0},
		'{ACT_REPORT,  7'd9,   72'hFF_00_FF_00_00_00_00_00_04, 1'b1, '{8'h61, 8'h04, 8'h00, 1'b1}},
		'{ACT_REPORT,  7'd8,   72'h00_FF_2C_00_00_00_00_00_00, 1'b1, '{8'h20, 8'h2C, 8'h00, 1'b1}},
		'{ACT_REPORT,  7'd8,   72'h02_00_00_07_00_08_00_00_00, 1'b0, '0},
		'{ACT_REPORT,  7'd8,   72'h02_00_00_07_00_08_09_00_00, 1'b0, '0},
		'{ACT_REPORT,  7'd8,   72'h00_00_00_00_00_00_00_00_00, 1'b0, '0}
	};

	hid_boot_keyboard_report_decoder i_dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// US layout character for a keycode; 0 when the key has no character
	function automatic byte_t us_qwerty(input byte_t kc, input logic shift);
		byte_t lo, hi;
		lo = 8'h00;
		hi = 8'h00;
		if (kc >= 8'h04 && kc <= 8'h1D)
			return (shift ? "A" : "a") + (kc - 8'h04);
		if (kc >= 8'h1E && kc <= 8'h27)
			return shift ? DIGITS_HI[kc - 8'h1E] : DIGITS_LO[kc - 8'h1E];
		case (kc)
			8'h28: begin lo = 8'h0A; hi = 8'h0A; end
			8'h2A: begin lo = 8'h08; hi = 8'h08; end
			8'h2B: begin lo = 8'h09; hi = 8'h09; end
			8'h2C: begin lo = " ";   hi = " ";   end
			8'h2D: begin lo = "-";   hi = "_";   end
			8'h2E: begin lo = "=";   hi = "+";   end
			8'h2F: begin lo = "[";   hi = "{";   end
			8'h30: begin lo = "]";   hi = "}";   end
			8'h31: begin lo = "\\";  hi = "|";   end
			8'h33: begin lo = ";";   hi = ":";   end
			8'h34: begin lo = "'";   hi = "\"";  end
			8'h36: begin lo = ",";   hi = "<";   end
			8'h37: begin lo = ".";   hi = ">";   end
			8'h38: begin lo = "/";   hi = "?";   end
			default: ;
		endcase
		return shift ? hi : lo;
	endfunction

	// decode one accepted word, update the held keys, return the number of presses
	function automatic int decode_report(input report_word_t w, output key_event_t ev [KEY_SLOTS]);
		int    n, ofs, i, j;
		byte_t mods;
		byte_t slot [KEY_SLOTS];
		logic  held;
		n = 0;
		if (w.act == ACT_CONNECT) begin
			foreach (held_keys[k]) held_keys[k] = 8'h00;
			return 0;
		end
		if (w.len < MIN_LEN)
			return 0;
		ofs = (w.len == REPORT_ID_LEN) ? 1 : 0;
		mods = w.b[ofs];
		for (i = 0; i < KEY_SLOTS; i++)
			slot[i] = (i < BOOT_KEY_BYTES) ? w.b[ofs + 2 + i] : 8'h00;
		for (i = 0; i < KEY_SLOTS; i++) begin
			held = 1'b0;
			for (j = 0; j < KEY_SLOTS; j++)
				if (held_keys[j] == slot[i]) held = 1'b1;
			if (slot[i] != 8'h00 && !held) begin
				ev[n] = '{us_qwerty(slot[i], (mods & SHIFT_MASK) != 8'h00), slot[i], mods, 1'b0};
				n++;
			end
		end
		if (n > 0)
			ev[n - 1].last = 1'b1;
		held_keys = slot;
		return n;
	endfunction

	task automatic flag_error(input string what);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	// present one word, wait for the handshake, then queue its key presses
	task automatic send_word(input report_word_t w);
		int         gap, n, i;
		key_event_t ev [KEY_SLOTS];
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= w.act;
		report_length <= w.len;
		byte_0 <= w.b[0];
		byte_1 <= w.b[1];
		byte_2 <= w.b[2];
		byte_3 <= w.b[3];
		byte_4 <= w.b[4];
		byte_5 <= w.b[5];
		byte_6 <= w.b[6];
		byte_7 <= w.b[7];
		byte_8 <= w.b[8];
		@(negedge clk);
		while (in_ready !== 1'b1) @(negedge clk);
		@(posedge clk);
		n = decode_report(w, ev);
		if (w.typed)
			pending_keys.push_back(w.ev);
		else
			for (i = 0; i < n; i++) pending_keys.push_back(ev[i]);
	endtask

	// hold the sender until every queued press has come out
	task automatic drain_keys();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_keys.size() != 0);
	endtask

	// result side: random stall before each word, then ready until it is taken
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (out_valid !== 1'b1) @(negedge clk);
			@(posedge clk);
		end
	end

	// compare each accepted word with the oldest pending press
	always @(negedge clk) begin
		key_event_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_keys.size() == 0) begin
				flag_error($sformatf("unexpected word ascii=%02h key=%02h mods=%02h last=%0b",
					ascii_code, key_code, modifier_bits, last_of_report));
			end else begin
				want = pending_keys.pop_front();
				if (ascii_code !== want.ascii || key_code !== want.key ||
						modifier_bits !== want.mods || last_of_report !== want.last)
					flag_error($sformatf(
						"exp ascii=%02h key=%02h mods=%02h last=%0b, got ascii=%02h key=%02h mods=%02h last=%0b",
						want.ascii, want.key, want.mods, want.last,
						ascii_code, key_code, modifier_bits, last_of_report));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("hid_boot_keyboard_report_decoder_tb NOT OK");
			$finish;
		end
	end

	initial begin
		report_word_t w;
		int           k, i, pick, sel, ofs;
		fail_cnt = 0;
		cycles   = 0;
		tx_calm  = 1'b0;
		rx_calm  = 1'b0;
		foreach (held_keys[j]) held_keys[j] = 8'h00;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		action        <= ACT_REPORT;
		report_length <= '0;
		byte_0 <= '0;
		byte_1 <= '0;
		byte_2 <= '0;
		byte_3 <= '0;
		byte_4 <= '0;
		byte_5 <= '0;
		byte_6 <= '0;
		byte_7 <= '0;
		byte_8 <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[r])
			send_word(DIRECTED[r]);
		drain_keys();

		// random typing: mostly held keys plus fresh presses, some noise
		for (k = 0; k < RAND_WORDS; k++) begin
			if (k % 40 == 0) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			if (k == RAND_WORDS / 2)
				drain_keys();
			w       = '0;
			w.act   = ACT_REPORT;
			w.b     = {$urandom, $urandom, 8'($urandom)};
			w.len   = MIN_LEN;
			pick    = $urandom_range(0, 99);
			if (pick < 3) begin
				w.act = ACT_CONNECT;
			end else if (pick < 9) begin
				w.len = 7'($urandom_range(0, MIN_LEN - 1));
			end else begin
				sel = $urandom_range(0, 19);
				if (sel >= 17)
					w.len = 7'($urandom_range(10, 127));
				else if (sel >= 12)
					w.len = REPORT_ID_LEN;
				ofs = (w.len == REPORT_ID_LEN) ? 1 : 0;
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 3))
						0: w.b[ofs] = 8'h02;
						1: w.b[ofs] = 8'h20;
						2: w.b[ofs] = SHIFT_MASK;
						default: w.b[ofs] = 8'h00;
					endcase
				end
				for (i = 0; i < BOOT_KEY_BYTES; i++) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: w.b[ofs + 2 + i] = held_keys[i];
						4: w.b[ofs + 2 + i] = held_keys[$urandom_range(0, KEY_SLOTS - 1)];
						5: w.b[ofs + 2 + i] = 8'h00;
						6, 7, 8: w.b[ofs + 2 + i] = 8'($urandom_range(8'h04, 8'h38));
						default: ;
					endcase
				end
			end
			send_word(w);
		end

		drain_keys();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && pending_keys.size() == 0)
			$display("hid_boot_keyboard_report_decoder_tb OK");
		else
			$display("hid_boot_keyboard_report_decoder_tb NOT OK");
		$finish;
	end

endmodule
